[src/ate_pkg.sv]
`timescale 1ns / 1ps

package ate_pkg;

    // Store geometry.
    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int WORD_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    // Capacity after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(10);

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_GET     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SET     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SEARCH  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_BSEARCH = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd3;

    // One request item.
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] value;
        logic [ADDR_W-1:0]        index;
        logic [ADDR_W-1:0]        low_index;
        logic [ADDR_W-1:0]        high_index;
    } req_t;

    // One result item.
    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [ADDR_W-1:0]        position;
        logic [STATUS_W-1:0]      status;
        logic [CNT_W-1:0]         count;
    } rsp_t;

    // Memory port controls from the sequencer.
    typedef struct packed {
        logic                     rd_en;
        logic [ADDR_W-1:0]        rd_addr;
        logic                     wr_en;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [WORD_W-1:0] wr_data;
    } mem_req_t;

endpackage

[src/ate_if.sv]
`timescale 1ns / 1ps

// Request channel.
interface ate_req_if;
    import ate_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] value;
    logic [ADDR_W-1:0]        index;
    logic [ADDR_W-1:0]        low_index;
    logic [ADDR_W-1:0]        high_index;

    modport source (output valid, func, value, index, low_index, high_index, input ready);
    modport sink   (input valid, func, value, index, low_index, high_index, output ready);
endinterface

// Result channel.
interface ate_rsp_if;
    import ate_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] data;
    logic [ADDR_W-1:0]        position;
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         count;

    modport source (output valid, data, position, status, count, input ready);
    modport sink   (input valid, data, position, status, count, output ready);
endinterface

[src/ate_mem.sv]
`timescale 1ns / 1ps

module ate_mem (
    input  logic                              clk,
    input  ate_pkg::mem_req_t                 mem_req,
    output logic signed [ate_pkg::WORD_W-1:0] rd_data
);
    import ate_pkg::*;

    logic signed [WORD_W-1:0] mem_array [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem_array[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data <= mem_array[mem_req.rd_addr];
        end
    end

endmodule

[src/ate_ctrl.sv]
`timescale 1ns / 1ps

module ate_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ate_pkg::req_t                     in_item,
    input  logic [ate_pkg::CNT_W-1:0]         cap,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ate_pkg::rsp_t                     out_item,
    output ate_pkg::mem_req_t                 mem_req,
    input  logic signed [ate_pkg::WORD_W-1:0] rd_data
);
    import ate_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_INS  = 8'b0000_0010,
        S_DEL  = 8'b0000_0100,
        S_GET  = 8'b0000_1000,
        S_SRCH = 8'b0001_0000,
        S_SWAP = 8'b0010_0000,
        S_BIN  = 8'b0100_0000,
        S_RESP = 8'b1000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic                     pend_reg, pend_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [ADDR_W-1:0]        la_reg, la_next;
    logic signed [WORD_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [ADDR_W-1:0]        hi_reg, hi_next;
    logic [ADDR_W-1:0]        mid_reg, mid_next;
    logic signed [WORD_W-1:0] first_reg, first_next;
    logic signed [WORD_W-1:0] data_reg, data_next;
    logic [ADDR_W-1:0]        pos_reg, pos_next;
    logic [STATUS_W-1:0]      status_reg, status_next;

    logic                     key_eq;
    logic                     key_lt;
    logic [CNT_W-1:0]         count_m1;
    logic [CNT_W-1:0]         mid_sum;
    logic [CNT_W-1:0]         ptr_m1;

    // Shared compare unit on the word just read back.
    assign key_eq = (rd_data == key_reg);
    assign key_lt = (key_reg < rd_data);

    assign count_m1 = count_reg - CNT_W'(1);
    assign ptr_m1   = ptr_reg - CNT_W'(1);
    assign mid_sum  = CNT_W'(lo_reg[ADDR_W-1:0]) + CNT_W'(hi_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);

    always_comb
    begin
        out_item.data     = data_reg;
        out_item.position = pos_reg;
        out_item.status   = status_reg;
        out_item.count    = count_reg;
    end

    // Sequencer: issues the store reads and writes for each operation.
    always_comb
    begin
        state_next  = state_reg;
        pend_next   = 1'b0;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        la_next     = la_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        first_next  = first_reg;
        data_next   = data_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        mem_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next    = in_item.value;
                    idx_next    = in_item.index;
                    data_next   = '0;
                    pos_next    = '0;
                    status_next = ST_OK;
                    ptr_next    = '0;
                    case (in_item.func)
                        FN_INSERT:
                        begin
                            if (count_reg >= cap)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else if (CNT_W'(in_item.index) > count_reg)
                            begin
                                status_next = ST_BADIDX;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = S_INS;
                            end
                        end
                        FN_DELETE, FN_GET:
                        begin
                            if (CNT_W'(in_item.index) >= count_reg)
                            begin
                                status_next = ST_BADIDX;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                ptr_next   = CNT_W'(in_item.index);
                                state_next = (in_item.func == FN_DELETE) ? S_DEL : S_GET;
                            end
                        end
                        FN_SET:
                        begin
                            if (CNT_W'(in_item.index) >= count_reg)
                            begin
                                status_next = ST_BADIDX;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = in_item.index;
                                mem_req.wr_data = in_item.value;
                                data_next       = in_item.value;
                                pos_next        = in_item.index;
                            end
                            state_next = S_RESP;
                        end
                        FN_SEARCH:
                        begin
                            state_next = S_SRCH;
                        end
                        FN_BSEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_MISS;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                lo_next = CNT_W'(in_item.low_index);
                                if (CNT_W'(in_item.high_index) > count_m1)
                                begin
                                    hi_next = count_m1[ADDR_W-1:0];
                                end
                                else
                                begin
                                    hi_next = in_item.high_index;
                                end
                                state_next = S_BIN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_BADIDX;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end

            // Shift entries up from the top, then place the new word.
            S_INS:
            begin
                if (pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = la_reg;
                    mem_req.wr_data = rd_data;
                end
                if (ptr_reg > CNT_W'(idx_reg))
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_m1[ADDR_W-1:0];
                    la_next         = ptr_reg[ADDR_W-1:0];
                    ptr_next        = ptr_m1;
                    pend_next       = 1'b1;
                end
                else if (!pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = idx_reg;
                    mem_req.wr_data = key_reg;
                    count_next      = count_reg + CNT_W'(1);
                    data_next       = key_reg;
                    pos_next        = idx_reg;
                    state_next      = S_RESP;
                end
            end

            // Read the removed word, then move later entries down by one.
            S_DEL:
            begin
                if (pend_reg)
                begin
                    if (la_reg == idx_reg)
                    begin
                        data_next = rd_data;
                    end
                    else
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = la_reg - ADDR_W'(1);
                        mem_req.wr_data = rd_data;
                    end
                end
                if (ptr_reg < count_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg[ADDR_W-1:0];
                    la_next         = ptr_reg[ADDR_W-1:0];
                    ptr_next        = ptr_reg + CNT_W'(1);
                    pend_next       = 1'b1;
                end
                else
                begin
                    count_next = count_m1;
                    pos_next   = idx_reg;
                    state_next = S_RESP;
                end
            end

            S_GET:
            begin
                if (pend_reg)
                begin
                    data_next  = rd_data;
                    pos_next   = idx_reg;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg;
                    pend_next       = 1'b1;
                end
            end

            // Linear scan; a hit takes the old front word.
            S_SRCH:
            begin
                if (pend_reg && (la_reg == '0))
                begin
                    first_next = rd_data;
                end
                if (pend_reg && key_eq)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = la_reg;
                    mem_req.wr_data = (la_reg == '0) ? rd_data : first_reg;
                    state_next      = S_SWAP;
                end
                else if (ptr_reg < count_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg[ADDR_W-1:0];
                    la_next         = ptr_reg[ADDR_W-1:0];
                    ptr_next        = ptr_reg + CNT_W'(1);
                    pend_next       = 1'b1;
                end
                else
                begin
                    status_next = ST_MISS;
                    state_next  = S_RESP;
                end
            end

            // Put the key at the front.
            S_SWAP:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = '0;
                mem_req.wr_data = key_reg;
                data_next       = key_reg;
                pos_next        = '0;
                state_next      = S_RESP;
            end

            // Binary search: read the middle entry, then narrow the range.
            S_BIN:
            begin
                if (pend_reg)
                begin
                    if (key_eq)
                    begin
                        data_next  = key_reg;
                        pos_next   = mid_reg;
                        state_next = S_RESP;
                    end
                    else if (key_lt)
                    begin
                        if (mid_reg == '0)
                        begin
                            status_next = ST_MISS;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            hi_next = mid_reg - ADDR_W'(1);
                        end
                    end
                    else
                    begin
                        lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                    end
                end
                else if (lo_reg <= CNT_W'(hi_reg))
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mid_sum[CNT_W-1:1];
                    mid_next        = mid_sum[CNT_W-1:1];
                    pend_next       = 1'b1;
                end
                else
                begin
                    status_next = ST_MISS;
                    state_next  = S_RESP;
                end
            end

            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        la_reg     <= la_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        first_reg  <= first_next;
        data_reg   <= data_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
    end

    // The element count never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    // No read is left in flight when a new item can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_reg)
        else $error("pending read while idle");

    // A cycle never reads the entry it writes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
        else $error("read and write at one address");

    // The count moves by one at most per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != count_next) |->
            ((count_next == count_reg + CNT_W'(1)) || (count_next == count_m1)))
        else $error("count jumped");

endmodule

[src/array_table_engine.sv]
`timescale 1ns / 1ps
// Throughput: one item at a time; the store has one read and one write port and moves one entry per cycle.
// A finished result waits in the output register while the next request is taken.
// Reset clears the element count and sets capacity to 10; store contents stay undefined.

module array_table_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    ate_req_if.sink                      req,
    ate_rsp_if.source                    rsp,
    input  logic                         cfg_we,
    input  logic [ate_pkg::CNT_W-1:0]    cfg_wdata
);
    import ate_pkg::*;

    logic [CNT_W-1:0]         cap_reg;
    logic [CNT_W-1:0]         cap_eff;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_reg;
    req_t                     req_item;
    rsp_t                     ctrl_item;
    logic                     ctrl_valid;
    logic                     ctrl_ready;
    mem_req_t                 mem_req;
    logic signed [WORD_W-1:0] rd_data;

    // Capacity register, limited to the store depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    assign cap_eff = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;

    // Request payload.
    always_comb
    begin
        req_item.func       = req.func;
        req_item.value      = req.value;
        req_item.index      = req.index;
        req_item.low_index  = req.low_index;
        req_item.high_index = req.high_index;
    end

    ate_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_item   (req_item),
        .cap       (cap_eff),
        .out_valid (ctrl_valid),
        .out_ready (ctrl_ready),
        .out_item  (ctrl_item),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    ate_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Output register: loads when empty or when its result is taken.
    assign ctrl_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl_ready)
        begin
            rsp_valid_reg <= ctrl_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_ready && ctrl_valid)
        begin
            rsp_reg <= ctrl_item;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.data     = rsp_reg.data;
    assign rsp.position = rsp_reg.position;
    assign rsp.status   = rsp_reg.status;
    assign rsp.count    = rsp_reg.count;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ate_pkg::*;

    // Func codes the block does not implement; both must answer bad index.
    localparam logic [FUNC_W-1:0] FN_RSVD_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_B = 3'd7;

    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 100;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 100;

    typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_SORTED} mix_t;

    // One line of the directed stimulus: either a capacity write or a request.
    typedef struct {
        bit                is_cfg;
        logic [CNT_W-1:0]  cap;
        req_t              req;
        bit                exact;
        rsp_t              want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    ate_req_if req_if ();
    ate_rsp_if rsp_if ();

    array_table_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the array, its element count and the capacity register.
    logic signed [WORD_W-1:0] model_words [DEPTH];
    int                       model_count;
    int                       model_cap;

    rsp_t     pending_results [$];
    dir_row_t dir_rows [$];
    int       error_count;
    int       result_count;
    bit       sender_burst;
    bit       recv_burst;
    bit       recv_hold;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Every mismatch goes through here.
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: result %0d: %s", $realtime, result_count, msg);
        error_count++;
    endtask

    // Apply one operation to the shadow array and return the result it yields.
    function automatic rsp_t apply_table_op(input req_t r);
        rsp_t o;
        int   lim;
        int   i;
        int   l;
        int   h;
        int   mid;
        bit   done;

        o = '0;
        o.status = ST_OK;
        lim = (model_cap > DEPTH) ? DEPTH : model_cap;
        done = 1'b0;
        case (r.func)
            FN_INSERT:
            begin
                if (model_count >= lim)
                    o.status = ST_FULL;
                else if (int'(r.index) > model_count)
                    o.status = ST_BADIDX;
                else
                begin
                    for (i = model_count; i > int'(r.index); i--)
                        model_words[i] = model_words[i-1];
                    model_words[r.index] = r.value;
                    model_count++;
                    o.data = r.value;
                    o.position = r.index;
                end
            end
            FN_DELETE:
            begin
                if (int'(r.index) >= model_count)
                    o.status = ST_BADIDX;
                else
                begin
                    o.data = model_words[r.index];
                    for (i = r.index; i + 1 < model_count; i++)
                        model_words[i] = model_words[i+1];
                    model_count--;
                    o.position = r.index;
                end
            end
            FN_GET:
            begin
                if (int'(r.index) >= model_count)
                    o.status = ST_BADIDX;
                else
                begin
                    o.data = model_words[r.index];
                    o.position = r.index;
                end
            end
            FN_SET:
            begin
                if (int'(r.index) >= model_count)
                    o.status = ST_BADIDX;
                else
                begin
                    model_words[r.index] = r.value;
                    o.data = r.value;
                    o.position = r.index;
                end
            end
            FN_SEARCH:
            begin
                // A hit trades places with the entry at the front.
                o.status = ST_MISS;
                for (i = 0; i < model_count && !done; i++)
                begin
                    if (model_words[i] == r.value)
                    begin
                        model_words[i] = model_words[0];
                        model_words[0] = r.value;
                        o.data = r.value;
                        o.position = '0;
                        o.status = ST_OK;
                        done = 1'b1;
                    end
                end
            end
            FN_BSEARCH:
            begin
                // The upper bound is clamped to the last held entry.
                o.status = ST_MISS;
                if (model_count > 0)
                begin
                    l = r.low_index;
                    h = (int'(r.high_index) > model_count - 1) ? model_count - 1
                                                                : int'(r.high_index);
                    while (l <= h && !done)
                    begin
                        mid = (l + h) / 2;
                        if (model_words[mid] == r.value)
                        begin
                            o.data = r.value;
                            o.position = ADDR_W'(mid);
                            o.status = ST_OK;
                            done = 1'b1;
                        end
                        else if ($signed(r.value) < $signed(model_words[mid]))
                        begin
                            if (mid == 0)
                                done = 1'b1;
                            else
                                h = mid - 1;
                        end
                        else
                            l = mid + 1;
                    end
                end
            end
            default:
            begin
                o.status = ST_BADIDX;
            end
        endcase
        o.count = CNT_W'(model_count);
        return o;
    endfunction

    // Directed rows.
    function automatic dir_row_t op_row(input logic [FUNC_W-1:0] func,
                                        input logic signed [WORD_W-1:0] value,
                                        input int index, input int lo, input int hi);
        dir_row_t row;

        row = '{default: '0};
        row.req.func = func;
        row.req.value = value;
        row.req.index = ADDR_W'(index);
        row.req.low_index = ADDR_W'(lo);
        row.req.high_index = ADDR_W'(hi);
        return row;
    endfunction

    function automatic dir_row_t fixed_row(input dir_row_t row,
                                           input logic signed [WORD_W-1:0] data,
                                           input int pos, input logic [STATUS_W-1:0] status,
                                           input int count);
        row.exact = 1'b1;
        row.want.data = data;
        row.want.position = ADDR_W'(pos);
        row.want.status = status;
        row.want.count = CNT_W'(count);
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input int cap);
        dir_row_t row;

        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cap = CNT_W'(cap);
        return row;
    endfunction

    // Random field values: mostly a small pool so searches hit, plus extremes and fully random words.
    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed(32'($urandom_range(0, 40))) - 32'sd20;
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_key();
        if (model_count > 0 && $urandom_range(0, 9) < 6)
            return model_words[$urandom_range(0, model_count - 1)];
        return pick_value();
    endfunction

    function automatic logic [ADDR_W-1:0] pick_index();
        if ($urandom_range(0, 4) == 0)
            return ADDR_W'($urandom_range(0, DEPTH - 1));
        return ADDR_W'($urandom_range(0, (model_count > DEPTH - 1) ? DEPTH - 1 : model_count));
    endfunction

    // Build the next random request from the current contents of the array.
    function automatic req_t next_item(input mix_t mix);
        req_t r;
        int   roll;
        int   ins_w;
        int   del_w;
        int   n;
        int   i;

        r.func = FN_GET;
        r.value = pick_value();
        r.index = pick_index();
        r.low_index = ADDR_W'($urandom_range(0, DEPTH - 1));
        r.high_index = ADDR_W'($urandom_range(0, DEPTH - 1));
        roll = $urandom_range(0, 99);
        if (roll < 3)
            r.func = (roll == 0) ? FN_RSVD_A : FN_RSVD_B;
        else if (mix == MIX_SORTED)
        begin
            // Keep the array ascending so that binary search sees real ranges.
            if (roll < 40)
            begin
                r.func = FN_INSERT;
                n = 0;
                for (i = 0; i < model_count; i++)
                    if ($signed(model_words[i]) < $signed(r.value))
                        n++;
                r.index = ADDR_W'(n);
            end
            else if (roll < 52)
                r.func = FN_DELETE;
            else if (roll < 62)
                r.func = FN_GET;
            else
            begin
                r.func = FN_BSEARCH;
                r.value = pick_key();
                if ($urandom_range(0, 9) < 6)
                begin
                    r.low_index = '0;
                    r.high_index = '1;
                end
            end
        end
        else
        begin
            ins_w = (mix == MIX_FILL) ? 55 : (mix == MIX_DRAIN) ? 5 : 25;
            del_w = (mix == MIX_FILL) ? 5 : (mix == MIX_DRAIN) ? 50 : 15;
            roll = roll - 3;
            if (roll < ins_w)
                r.func = FN_INSERT;
            else if (roll < ins_w + del_w)
                r.func = FN_DELETE;
            else
            begin
                case ($urandom_range(0, 3))
                    0: r.func = FN_GET;
                    1: r.func = FN_SET;
                    2:
                    begin
                        r.func = FN_SEARCH;
                        r.value = pick_key();
                    end
                    default:
                    begin
                        r.func = FN_BSEARCH;
                        r.value = pick_key();
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Offer one request after a random gap, or none in a burst, and record what it should produce.
    task automatic offer_item(input req_t r, input bit exact, input rsp_t want);
        int   gap;
        rsp_t got;

        gap = sender_burst ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.func       <= r.func;
        req_if.value      <= r.value;
        req_if.index      <= r.index;
        req_if.low_index  <= r.low_index;
        req_if.high_index <= r.high_index;
        do
            @(posedge clk);
        while (!req_if.ready);
        got = apply_table_op(r);
        pending_results.push_back(exact ? want : got);
    endtask

    // Stop offering and wait until every expected result has been taken.
    task automatic drain_results();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Capacity is only written while the block holds no work.
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        model_cap = cap;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, idle-free stretches and one long hold-off.
    initial
    begin
        int stall;

        rsp_if.ready = 1'b0;
        forever
        begin
            if (recv_hold)
            begin
                stall = LONG_HOLD;
                recv_hold = 1'b0;
            end
            else
                stall = recv_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t want;

        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.data !== want.data)
                    report_mismatch($sformatf("data %0h, expected %0h",
                                              rsp_if.data, want.data));
                if (rsp_if.position !== want.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              rsp_if.position, want.position));
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_if.status, want.status));
                if (rsp_if.count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              rsp_if.count, want.count));
            end
            result_count++;
        end
    end

    // Run limit.
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        mix_t     mix;
        rsp_t     none;
        dir_row_t clr_row;
        int       ph;
        int       k;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        req_if.valid      = 1'b0;
        req_if.func       = FN_GET;
        req_if.value      = '0;
        req_if.index      = '0;
        req_if.low_index  = '0;
        req_if.high_index = '0;
        model_count       = 0;
        model_cap         = CAP_RESET;
        error_count       = 0;
        result_count      = 0;
        sender_burst      = 1'b0;
        recv_burst        = 1'b0;
        recv_hold         = 1'b0;
        none              = '0;
        for (k = 0; k < DEPTH; k++)
            model_words[k] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty array, unused codes and index limits, then a short fill.
        dir_rows.push_back(fixed_row(op_row(FN_GET, 0, 0, 0, 0), 0, 0, ST_BADIDX, 0));
        dir_rows.push_back(fixed_row(op_row(FN_DELETE, 0, 0, 0, 0), 0, 0, ST_BADIDX, 0));
        dir_rows.push_back(fixed_row(op_row(FN_BSEARCH, 0, 0, 0, 63), 0, 0, ST_MISS, 0));
        dir_rows.push_back(fixed_row(op_row(FN_SEARCH, -1, 0, 0, 0), 0, 0, ST_MISS, 0));
        dir_rows.push_back(fixed_row(op_row(FN_RSVD_A, 32'sh7fff_ffff, 63, 63, 63),
                                     0, 0, ST_BADIDX, 0));
        dir_rows.push_back(fixed_row(op_row(FN_RSVD_B, 32'sh8000_0000, 0, 0, 0),
                                     0, 0, ST_BADIDX, 0));
        dir_rows.push_back(fixed_row(op_row(FN_INSERT, 5, 1, 0, 0), 0, 0, ST_BADIDX, 0));
        dir_rows.push_back(fixed_row(op_row(FN_INSERT, 32'sh8000_0000, 0, 0, 0),
                                     32'sh8000_0000, 0, ST_OK, 1));
        dir_rows.push_back(fixed_row(op_row(FN_INSERT, 32'sh7fff_ffff, 1, 0, 0),
                                     32'sh7fff_ffff, 1, ST_OK, 2));
        dir_rows.push_back(fixed_row(op_row(FN_INSERT, 0, 1, 0, 0), 0, 1, ST_OK, 3));
        dir_rows.push_back(op_row(FN_GET, 0, 2, 0, 0));
        dir_rows.push_back(op_row(FN_SET, -1, 2, 0, 0));
        dir_rows.push_back(op_row(FN_BSEARCH, 0, 0, 0, 63));
        dir_rows.push_back(op_row(FN_SEARCH, -1, 0, 0, 0));
        dir_rows.push_back(op_row(FN_SEARCH, 12345, 0, 0, 0));
        dir_rows.push_back(fixed_row(op_row(FN_DELETE, 0, 3, 0, 0), 0, 0, ST_BADIDX, 3));
        dir_rows.push_back(fixed_row(op_row(FN_GET, 0, 63, 0, 0), 0, 0, ST_BADIDX, 3));
        dir_rows.push_back(op_row(FN_BSEARCH, 0, 0, 5, 0));
        dir_rows.push_back(op_row(FN_DELETE, 0, 0, 0, 0));
        // Full takes precedence over a bad index; zero capacity refuses all inserts.
        dir_rows.push_back(cfg_row(2));
        dir_rows.push_back(fixed_row(op_row(FN_INSERT, 9, 50, 0, 0), 0, 0, ST_FULL, 2));
        dir_rows.push_back(cfg_row(0));
        dir_rows.push_back(fixed_row(op_row(FN_INSERT, 9, 0, 0, 0), 0, 0, ST_FULL, 2));
        // Capacity above the store depth behaves as the depth.
        dir_rows.push_back(cfg_row(127));
        dir_rows.push_back(op_row(FN_INSERT, 5, 0, 0, 0));
        dir_rows.push_back(cfg_row(10));

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].is_cfg)
                write_capacity(dir_rows[k].cap);
            else
                offer_item(dir_rows[k].req, dir_rows[k].exact, dir_rows[k].want);
        end

        // Random phases, each under its own capacity and operation mix.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin write_capacity(CNT_W'(64));  mix = MIX_FILL;     end
                1: begin write_capacity(CNT_W'(127)); mix = MIX_BALANCED; end
                2: begin write_capacity(CNT_W'(1));   mix = MIX_BALANCED; end
                3: begin write_capacity(CNT_W'(0));   mix = MIX_DRAIN;    end
                4: begin write_capacity(CNT_W'(10));  mix = MIX_SORTED;   end
                5: begin write_capacity(CNT_W'(64));  mix = MIX_SORTED;   end
                default:
                begin
                    write_capacity(($urandom_range(0, 1) == 0) ? CNT_W'(64)
                                                              : CNT_W'($urandom_range(0, 127)));
                    mix = mix_t'($urandom_range(0, 3));
                end
            endcase
            sender_burst = ($urandom_range(0, 3) == 0);
            recv_burst   = ($urandom_range(0, 3) == 0);

            // Receiver holds off while the sender keeps pushing.
            if (ph == 1)
            begin
                sender_burst = 1'b1;
                recv_hold = 1'b1;
            end

            // Sorted phases start from an empty array.
            if (mix == MIX_SORTED)
                while (model_count > 0)
                begin
                    clr_row = op_row(FN_DELETE, 0, $urandom_range(0, model_count - 1), 0, 0);
                    offer_item(clr_row.req, 1'b0, none);
                end

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 7 && k == PHASE_ITEMS / 2)
                    drain_results();
                offer_item(next_item(mix), 1'b0, none);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
